// File: rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   // Default pool depth in blocks.
   localparam int MAX_BLOCKS_DEFAULT = 256;

   // Field widths.
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 16;
   localparam int COUNT_W = 9;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 3;
   localparam int CSR_W   = 2;
   localparam int DATA_W  = 32;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd2;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_FAULT   = 3'd1;
   localparam logic [STAT_W-1:0] ST_UNREADY = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;
   localparam logic [STAT_W-1:0] ST_BADADDR = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_BLOCK_SIZE  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   // Register reset values.
   localparam logic [ADDR_W-1:0]  POOL_BASE_RESET   = 32'd0;
   localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RESET  = 16'd4;
   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 9'd1;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FILL,
      S_RDWAIT,
      S_MUL,
      S_DIV,
      S_DONE
   } state_type;

   // Results of the divider.
   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] quotient;
      logic [SIZE_W-1:0] remainder;
   } div_result_type;

endpackage

// File: rtl/core/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fbpa_div.sv
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fbpa_pkg::ADDR_W-1:0]   dividend,
   input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
   output fbpa_pkg::div_result_type      result
);

   localparam int STEPS = fbpa_pkg::ADDR_W;
   localparam int CNT_W = $clog2(STEPS);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [fbpa_pkg::ADDR_W-1:0] quot_ff, quot_in;
   logic [fbpa_pkg::SIZE_W-1:0] rem_ff, rem_in;
   logic [fbpa_pkg::SIZE_W-1:0] divisor_ff, divisor_in;
   logic [fbpa_pkg::SIZE_W:0]   trial;
   logic                        take;

   // The partial remainder always stays below the divisor, so one
   // compare and subtract settles each quotient bit.
   assign trial = {rem_ff, quot_ff[fbpa_pkg::ADDR_W-1]};
   assign take  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[fbpa_pkg::ADDR_W-2:0], take};
         if (take) begin
            rem_in = fbpa_pkg::SIZE_W'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[fbpa_pkg::SIZE_W-1:0];
         end
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quot_ff;
   assign result.remainder = rem_ff;

endmodule

// File: rtl/core/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of equal-sized blocks with a circular FIFO of free block indices.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     op, release_address
//   rsp      out        rsp_valid/stall     status, block_address, blocks_free
//   csr      in         csr_write_enable    csr_index, csr_write_data
//
// Sequencing: one item at a time. Delete, refused and faulting items go
// from execute straight to done. Allocate reads the queue RAM, then
// multiplies, then adds. Create makes one fill write a cycle into the
// queue RAM. Release runs the restoring divider, one quotient bit a cycle.
// Reset: synchronous and active high; it clears the pool to not ready and
// loads the register defaults. The queue RAM is not cleared, since create
// writes every entry that is later read.
// Stalls: the result register holds an item until it is taken; the next
// item is accepted meanwhile, and its result waits in the sequencer.
//
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fbpa_pkg::OP_W-1:0]      req_op,
   input  logic [fbpa_pkg::ADDR_W-1:0]    req_release_address,
   // Response channel.
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fbpa_pkg::STAT_W-1:0]    rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]    rsp_block_address,
   output logic [fbpa_pkg::COUNT_W-1:0]   rsp_blocks_free,
   // Configuration port.
   input  logic                           csr_write_enable,
   input  logic [fbpa_pkg::CSR_W-1:0]     csr_index,
   input  logic [fbpa_pkg::DATA_W-1:0]    csr_write_data
);

   // Index and pointer width of the free queue, and product width.
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int PW = IW + fbpa_pkg::SIZE_W;
   localparam int CW = fbpa_pkg::COUNT_W;

   // Configuration registers.
   logic [fbpa_pkg::ADDR_W-1:0] pool_base_ff;
   logic [fbpa_pkg::SIZE_W-1:0] block_size_ff;
   logic [CW-1:0]               block_count_ff;

   // Pool state.
   fbpa_pkg::state_type         state_ff, state_in;
   logic                        ready_ff, ready_in;
   logic [IW-1:0]               head_ff, head_in;
   logic [IW-1:0]               tail_ff, tail_in;
   logic [CW-1:0]               free_count_ff, free_count_in;
   logic [fbpa_pkg::ADDR_W-1:0] lat_base_ff, lat_base_in;
   logic [fbpa_pkg::SIZE_W-1:0] lat_size_ff, lat_size_in;
   logic [CW-1:0]               lat_count_ff, lat_count_in;

   // Item in flight.
   logic [fbpa_pkg::OP_W-1:0]   op_ff, op_in;
   logic [fbpa_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [IW-1:0]               fill_ff, fill_in;
   logic [PW-1:0]               prod_ff, prod_in;
   logic [fbpa_pkg::STAT_W-1:0] status_ff, status_in;
   logic [fbpa_pkg::ADDR_W-1:0] baddr_ff, baddr_in;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [fbpa_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [fbpa_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [CW-1:0]               rsp_free_ff, rsp_free_in;

   // Queue RAM and divider hookup.
   logic                        ram_wr_en;
   logic [IW-1:0]               ram_wr_addr;
   logic [IW-1:0]               ram_wr_data;
   logic                        ram_rd_en;
   logic [IW-1:0]               ram_rd_data;
   logic                        div_start;
   logic [fbpa_pkg::ADDR_W-1:0] div_dividend;
   fbpa_pkg::div_result_type    div_res;

   // Create saturates the requested count to the queue depth.
   logic [CW-1:0]               create_count;
   logic                        req_accept;
   logic                        rsp_free_slot;

   assign create_count = (32'(block_count_ff) > 32'(MAX_BLOCKS)) ?
                         CW'(MAX_BLOCKS) : block_count_ff;
   assign req_accept    = req_valid && !req_stall;
   assign rsp_free_slot = !rsp_valid_ff || !rsp_stall;

   // Wrap a queue pointer at the queue depth, which need not be a power of two.
   function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] p);
      if (32'(p) == 32'(MAX_BLOCKS - 1)) begin
         return '0;
      end
      return p + IW'(1);
   endfunction

   fbpa_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_BLOCKS)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   fbpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (lat_size_ff),
      .result   (div_res)
   );

   // Configuration writes. An index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= fbpa_pkg::POOL_BASE_RESET;
         block_size_ff  <= fbpa_pkg::BLOCK_SIZE_RESET;
         block_count_ff <= fbpa_pkg::BLOCK_COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            fbpa_pkg::CSR_POOL_BASE: begin
               pool_base_ff <= csr_write_data;
            end
            fbpa_pkg::CSR_BLOCK_SIZE: begin
               block_size_ff <= csr_write_data[fbpa_pkg::SIZE_W-1:0];
            end
            fbpa_pkg::CSR_BLOCK_COUNT: begin
               block_count_ff <= csr_write_data[CW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer: next state, pool updates and result staging.
   always_comb begin
      state_in      = state_ff;
      ready_in      = ready_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_count_in = free_count_ff;
      lat_base_in   = lat_base_ff;
      lat_size_in   = lat_size_ff;
      lat_count_in  = lat_count_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      fill_in       = fill_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;
      baddr_in      = baddr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_free_in   = rsp_free_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = fill_ff;
      ram_wr_data   = IW'(lat_count_ff - CW'(1) - CW'(fill_ff));
      ram_rd_en     = 1'b0;
      div_start     = 1'b0;
      div_dividend  = addr_ff - lat_base_ff;
      req_stall     = 1'b1;

      case (state_ff)
         fbpa_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_accept) begin
               op_in    = req_op;
               addr_in  = req_release_address;
               state_in = fbpa_pkg::S_EXEC;
            end
         end

         fbpa_pkg::S_EXEC: begin
            status_in = fbpa_pkg::ST_OK;
            baddr_in  = '0;
            state_in  = fbpa_pkg::S_DONE;
            if (op_ff == fbpa_pkg::OP_CREATE) begin
               if (ready_ff || create_count == '0 || block_size_ff == '0) begin
                  status_in = fbpa_pkg::ST_FAULT;
               end else begin
                  lat_base_in  = pool_base_ff;
                  lat_size_in  = block_size_ff;
                  lat_count_in = create_count;
                  fill_in      = '0;
                  state_in     = fbpa_pkg::S_FILL;
               end
            end else if (!ready_ff) begin
               status_in = fbpa_pkg::ST_UNREADY;
            end else if (op_ff == fbpa_pkg::OP_DELETE) begin
               if (free_count_ff == lat_count_ff) begin
                  ready_in      = 1'b0;
                  head_in       = '0;
                  tail_in       = '0;
                  free_count_in = '0;
                  lat_base_in   = '0;
                  lat_size_in   = '0;
                  lat_count_in  = '0;
               end else begin
                  status_in = fbpa_pkg::ST_FAULT;
               end
            end else if (op_ff == fbpa_pkg::OP_ALLOC) begin
               if (free_count_ff == '0) begin
                  status_in = fbpa_pkg::ST_EMPTY;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = fbpa_pkg::S_RDWAIT;
               end
            end else begin
               // Release: the full check comes ahead of the address checks.
               if (free_count_ff >= lat_count_ff) begin
                  status_in = fbpa_pkg::ST_FULL;
               end else if (addr_ff < lat_base_ff) begin
                  status_in = fbpa_pkg::ST_BADADDR;
               end else begin
                  div_start = 1'b1;
                  state_in  = fbpa_pkg::S_DIV;
               end
            end
         end

         fbpa_pkg::S_FILL: begin
            // Entry i gets block count - 1 - i, so the last block leads.
            ram_wr_en = 1'b1;
            fill_in   = fill_ff + IW'(1);
            if (32'(fill_ff) == 32'(lat_count_ff) - 32'd1) begin
               head_in       = '0;
               tail_in       = (32'(lat_count_ff) == 32'(MAX_BLOCKS)) ?
                               '0 : IW'(lat_count_ff);
               free_count_in = lat_count_ff;
               ready_in      = 1'b1;
               state_in      = fbpa_pkg::S_DONE;
            end
         end

         fbpa_pkg::S_RDWAIT: begin
            prod_in  = PW'(ram_rd_data) * PW'(lat_size_ff);
            state_in = fbpa_pkg::S_MUL;
         end

         fbpa_pkg::S_MUL: begin
            baddr_in      = lat_base_ff + fbpa_pkg::ADDR_W'(prod_ff);
            head_in       = next_slot(head_ff);
            free_count_in = free_count_ff - CW'(1);
            state_in      = fbpa_pkg::S_DONE;
         end

         fbpa_pkg::S_DIV: begin
            if (div_res.done) begin
               state_in = fbpa_pkg::S_DONE;
               if (div_res.quotient >= 32'(lat_count_ff) ||
                   div_res.remainder != '0) begin
                  status_in = fbpa_pkg::ST_BADADDR;
               end else begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = tail_ff;
                  ram_wr_data   = IW'(div_res.quotient);
                  tail_in       = next_slot(tail_ff);
                  free_count_in = free_count_ff + CW'(1);
               end
            end
         end

         fbpa_pkg::S_DONE: begin
            // The result leaves once the output register is free.
            if (rsp_free_slot) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = baddr_ff;
               rsp_free_in   = free_count_ff;
               state_in      = fbpa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = fbpa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fbpa_pkg::S_IDLE;
         ready_ff      <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_count_ff <= '0;
         lat_base_ff   <= '0;
         lat_size_ff   <= '0;
         lat_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ready_ff      <= ready_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_count_ff <= free_count_in;
         lat_base_ff   <= lat_base_in;
         lat_size_ff   <= lat_size_in;
         lat_count_ff  <= lat_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      fill_ff       <= fill_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      baddr_ff      <= baddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_blocks_free   = rsp_free_ff;

   // A live pool never holds more free blocks than it was created with.
   assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> free_count_ff <= lat_count_ff)
      else $error("free count above pool size");

   // Without a pool there are no free blocks to hand out.
   assert property (@(posedge clock) disable iff (reset)
      !ready_ff |-> free_count_ff == '0)
      else $error("free blocks while pool not ready");

   // The divider only finishes while a release waits on it.
   assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == fbpa_pkg::S_DIV)
      else $error("divider result outside release");

   // A staged result goes out in the next cycle whenever the output is free.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbpa_pkg::S_DONE && rsp_free_slot) |=>
      (rsp_valid_ff && state_ff == fbpa_pkg::S_IDLE))
      else $error("staged result not delivered");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed block pool allocator.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and handed to the block by a
// driver that changes its outputs on the falling clock edge. Every request
// the block accepts is run through a cycle-free copy of the pool: free index
// FIFO, head and tail, free count and the values latched at create. The
// reply that copy produces is queued. A monitor compares every reply the
// block hands out against the oldest queued one, field by field.
// The run starts with a directed sequence covering every operation and every
// error status, then walks through many random pool geometries.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_DEPTH    = fbpa_pkg::MAX_BLOCKS_DEFAULT;
   localparam int IDLE_PERCENT  = 24;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEM_TARGET   = 950;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [fbpa_pkg::OP_W-1:0]   op;
      logic [fbpa_pkg::ADDR_W-1:0] address;
   } pool_request_type;

   typedef struct packed {
      logic [fbpa_pkg::STAT_W-1:0]  status;
      logic [fbpa_pkg::ADDR_W-1:0]  block_address;
      logic [fbpa_pkg::COUNT_W-1:0] blocks_free;
   } pool_reply_type;

   // Every input of the block starts at a known value.
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [fbpa_pkg::OP_W-1:0]     req_op = fbpa_pkg::OP_CREATE;
   logic [fbpa_pkg::ADDR_W-1:0]   req_release_address = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [fbpa_pkg::STAT_W-1:0]   rsp_status;
   logic [fbpa_pkg::ADDR_W-1:0]   rsp_block_address;
   logic [fbpa_pkg::COUNT_W-1:0]  rsp_blocks_free;
   logic                          csr_write_enable = 1'b0;
   logic [fbpa_pkg::CSR_W-1:0]    csr_index = fbpa_pkg::CSR_POOL_BASE;
   logic [fbpa_pkg::DATA_W-1:0]   csr_write_data = '0;

   fixed_block_pool_allocator #(
      .MAX_BLOCKS(POOL_DEPTH)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_release_address (req_release_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_block_address   (rsp_block_address),
      .rsp_blocks_free     (rsp_blocks_free),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // Requests waiting to be offered, and replies the pool copy predicts.
   pool_request_type request_backlog[$];
   pool_reply_type   expected_replies[$];
   int               mismatches = 0;
   // Every item ever queued, directed and random alike.
   int               queued_items = 0;

   // Set when the block took the item on the rising edge, so that the driver
   // moves on to the next one at the following falling edge.
   bit item_taken = 1'b0;
   // No idling on either side while this is set.
   bit calm = 1'b0;
   // Asks the receiver process for one long hold-off.
   bit hold_armed = 1'b0;
   int hold_left = 0;

   // Mirror of the configuration registers as last written.
   logic [fbpa_pkg::ADDR_W-1:0]  cfg_base  = fbpa_pkg::POOL_BASE_RESET;
   logic [fbpa_pkg::SIZE_W-1:0]  cfg_size  = fbpa_pkg::BLOCK_SIZE_RESET;
   logic [fbpa_pkg::COUNT_W-1:0] cfg_count = fbpa_pkg::BLOCK_COUNT_RESET;

   // The pool as the block should hold it.
   bit                           pool_ready = 1'b0;
   int unsigned                  free_slots[POOL_DEPTH];
   int unsigned                  slot_head = 0;
   int unsigned                  slot_tail = 0;
   logic [fbpa_pkg::COUNT_W-1:0] free_total = '0;
   logic [fbpa_pkg::ADDR_W-1:0]  lat_base = '0;
   logic [fbpa_pkg::SIZE_W-1:0]  lat_size = '0;
   logic [fbpa_pkg::COUNT_W-1:0] lat_count = '0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Applies one operation to the pool copy and returns the reply it causes.
   // Create is the only operation that reads the live registers; all others
   // work on the values latched when the pool was created.
   task automatic apply_pool_op(input logic [fbpa_pkg::OP_W-1:0] op,
                                input logic [fbpa_pkg::ADDR_W-1:0] address,
                                output pool_reply_type reply);
      logic [fbpa_pkg::COUNT_W-1:0] span;
      logic [fbpa_pkg::ADDR_W-1:0]  offset;
      logic [fbpa_pkg::ADDR_W-1:0]  index;
      reply.status = fbpa_pkg::ST_OK;
      reply.block_address = '0;
      if (op == fbpa_pkg::OP_CREATE) begin
         // A count above the pool depth is clipped, not refused.
         span = (cfg_count > POOL_DEPTH) ? fbpa_pkg::COUNT_W'(POOL_DEPTH) : cfg_count;
         if (pool_ready || span == 0 || cfg_size == 0) begin
            reply.status = fbpa_pkg::ST_FAULT;
         end else begin
            // The last block goes to the head, block 0 to the tail.
            for (int i = 0; i < span; i++) begin
               free_slots[i] = span - 1 - i;
            end
            slot_head = 0;
            slot_tail = span % POOL_DEPTH;
            free_total = span;
            lat_base = cfg_base;
            lat_size = cfg_size;
            lat_count = span;
            pool_ready = 1'b1;
         end
      end else if (!pool_ready) begin
         reply.status = fbpa_pkg::ST_UNREADY;
      end else if (op == fbpa_pkg::OP_DELETE) begin
         // Only a pool with nothing handed out may be torn down.
         if (free_total == lat_count) begin
            pool_ready = 1'b0;
            slot_head = 0;
            slot_tail = 0;
            free_total = '0;
            lat_base = '0;
            lat_size = '0;
            lat_count = '0;
         end else begin
            reply.status = fbpa_pkg::ST_FAULT;
         end
      end else if (op == fbpa_pkg::OP_ALLOC) begin
         if (free_total == 0) begin
            reply.status = fbpa_pkg::ST_EMPTY;
         end else begin
            // The address wraps at 32 bits.
            reply.block_address = lat_base + free_slots[slot_head] * lat_size;
            slot_head = (slot_head + 1) % POOL_DEPTH;
            free_total = free_total - 1'b1;
         end
      end else begin
         // A full pool is reported before the address is looked at.
         if (free_total >= lat_count) begin
            reply.status = fbpa_pkg::ST_FULL;
         end else if (address < lat_base) begin
            reply.status = fbpa_pkg::ST_BADADDR;
         end else begin
            offset = address - lat_base;
            index = offset / lat_size;
            if (index >= lat_count || offset % lat_size != 0) begin
               reply.status = fbpa_pkg::ST_BADADDR;
            end else begin
               // Freeing a block twice is not caught; it simply goes back in.
               free_slots[slot_tail] = index;
               slot_tail = (slot_tail + 1) % POOL_DEPTH;
               free_total = free_total + 1'b1;
            end
         end
      end
      reply.blocks_free = free_total;
   endtask

   function automatic void queue_op(input logic [fbpa_pkg::OP_W-1:0] op,
                                    input logic [fbpa_pkg::ADDR_W-1:0] address);
      request_backlog.push_back('{op, address});
      queued_items++;
   endfunction

   // Release addresses for the random part. Most are block starts of the
   // pool that is being set up; the rest land off a block start, below the
   // base, past the last block, or anywhere at all.
   function automatic logic [fbpa_pkg::ADDR_W-1:0] pick_release_address();
      int unsigned span;
      int unsigned pick;
      span = (cfg_count > POOL_DEPTH) ? POOL_DEPTH : cfg_count;
      pick = $urandom_range(99);
      if (span == 0 || cfg_size == 0)
         return $urandom;
      if (pick < 70)
         return cfg_base + $urandom_range(span - 1) * cfg_size;
      if (pick < 78 && cfg_size > 1)
         return cfg_base + $urandom_range(span - 1) * cfg_size
                + $urandom_range(cfg_size - 1, 1);
      if (pick < 86 && cfg_base > 0)
         return $urandom_range(cfg_base - 1, 0);
      if (pick < 93)
         return cfg_base + (span + $urandom_range(3)) * cfg_size;
      return $urandom;
   endfunction

   // Waits until every queued item has gone in and every reply has come out,
   // then lets the clock run on so that the block can return to idle.
   task automatic settle();
      while (request_backlog.size() != 0 || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write, only ever issued while the block is idle.
   task automatic write_csr(input logic [fbpa_pkg::CSR_W-1:0] index,
                            input logic [fbpa_pkg::DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (index)
         fbpa_pkg::CSR_POOL_BASE: begin
            cfg_base = data;
         end
         fbpa_pkg::CSR_BLOCK_SIZE: begin
            cfg_size = data[fbpa_pkg::SIZE_W-1:0];
         end
         fbpa_pkg::CSR_BLOCK_COUNT: begin
            cfg_count = data[fbpa_pkg::COUNT_W-1:0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // Returns whatever pool is live to the not-ready state. Releasing block
   // starts until the pool is full always succeeds, whichever blocks are
   // actually out, so the delete that follows is always accepted.
   task automatic tear_down();
      logic [fbpa_pkg::ADDR_W-1:0] back;
      settle();
      if (pool_ready) begin
         repeat (lat_count - free_total) begin
            back = lat_base + $urandom_range(lat_count - 1) * lat_size;
            // A block start that wraps past the top of the address space
            // reads as below the base, so block 0 goes back in its place.
            if (back < lat_base)
               back = lat_base;
            queue_op(fbpa_pkg::OP_RELEASE, back);
         end
         queue_op(fbpa_pkg::OP_DELETE, $urandom);
         settle();
      end
   endtask

   // Stimulus.
   initial begin
      int phase;
      int burst;
      int pick;
      logic [fbpa_pkg::SIZE_W-1:0] size_pick;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Directed part, first on the reset register values: every operation
      // is refused before a create, then a one-block pool at address 0.
      queue_op(fbpa_pkg::OP_ALLOC, '0);
      queue_op(fbpa_pkg::OP_RELEASE, '0);
      queue_op(fbpa_pkg::OP_DELETE, '0);
      queue_op(fbpa_pkg::OP_CREATE, '0);
      queue_op(fbpa_pkg::OP_RELEASE, 32'd0);   // nothing handed out yet: full
      queue_op(fbpa_pkg::OP_ALLOC, '0);
      queue_op(fbpa_pkg::OP_ALLOC, '0);        // empty
      queue_op(fbpa_pkg::OP_DELETE, '0);       // block still out: fault
      queue_op(fbpa_pkg::OP_RELEASE, 32'd4);   // one past the last block
      queue_op(fbpa_pkg::OP_RELEASE, 32'd2);   // inside block 0, not at its start
      queue_op(fbpa_pkg::OP_RELEASE, 32'd0);
      queue_op(fbpa_pkg::OP_DELETE, '0);
      settle();

      // A four-block pool: second create, below-base and top-of-range
      // addresses, then a clean delete.
      write_csr(fbpa_pkg::CSR_POOL_BASE, 32'h0000_1000);
      write_csr(fbpa_pkg::CSR_BLOCK_SIZE, 32'd16);
      write_csr(fbpa_pkg::CSR_BLOCK_COUNT, 32'd4);
      queue_op(fbpa_pkg::OP_CREATE, '0);
      queue_op(fbpa_pkg::OP_CREATE, '0);       // already created: fault
      queue_op(fbpa_pkg::OP_ALLOC, '0);
      queue_op(fbpa_pkg::OP_RELEASE, 32'h0000_0FFF);
      queue_op(fbpa_pkg::OP_RELEASE, 32'hFFFF_FFFF);
      queue_op(fbpa_pkg::OP_RELEASE, 32'h0000_1030);
      queue_op(fbpa_pkg::OP_DELETE, '0);
      settle();

      // Zero size and zero count are refused at create.
      write_csr(fbpa_pkg::CSR_BLOCK_SIZE, 32'd0);
      queue_op(fbpa_pkg::OP_CREATE, '0);
      settle();
      write_csr(fbpa_pkg::CSR_BLOCK_SIZE, 32'd65535);
      write_csr(fbpa_pkg::CSR_BLOCK_COUNT, 32'd0);
      queue_op(fbpa_pkg::OP_CREATE, '0);
      settle();

      // Largest count, clipped to the pool depth, near the top of the
      // address space so that the last block's address wraps. Handing that
      // address back lands below the base.
      write_csr(fbpa_pkg::CSR_POOL_BASE, 32'hFFFF_0000);
      write_csr(fbpa_pkg::CSR_BLOCK_COUNT, 32'd511);
      queue_op(fbpa_pkg::OP_CREATE, '0);
      queue_op(fbpa_pkg::OP_ALLOC, '0);
      queue_op(fbpa_pkg::OP_RELEASE, 32'hFFFF_0000 + 32'd255 * 32'd65535);

      // Random part: one pool geometry after another, each created and then
      // exercised with a mix that keeps it swinging between empty and full.
      phase = 0;
      while (queued_items < ITEM_TARGET) begin
         tear_down();

         pick = $urandom_range(99);
         if (pick < 15)
            write_csr(fbpa_pkg::CSR_POOL_BASE, 32'h0);
         else if (pick < 22)
            write_csr(fbpa_pkg::CSR_POOL_BASE, 32'hFFFF_FFFF - $urandom_range(4095));
         else if (pick < 25)
            write_csr(fbpa_pkg::CSR_POOL_BASE, 32'hFFFF_FFFF);
         else
            write_csr(fbpa_pkg::CSR_POOL_BASE, $urandom);

         pick = $urandom_range(99);
         if (pick < 20)
            size_pick = 16'd1;
         else if (pick < 30)
            size_pick = 16'd65535;
         else if (pick < 60)
            size_pick = fbpa_pkg::SIZE_W'($urandom_range(64, 1));
         else if (pick < 62)
            size_pick = 16'd0;
         else
            size_pick = fbpa_pkg::SIZE_W'($urandom_range(65535, 1));
         write_csr(fbpa_pkg::CSR_BLOCK_SIZE, {16'h0, size_pick});

         // Small pools keep release and create cheap; a few are large.
         pick = $urandom_range(99);
         if (pick < 70)
            write_csr(fbpa_pkg::CSR_BLOCK_COUNT, $urandom_range(12, 1));
         else if (pick < 78)
            write_csr(fbpa_pkg::CSR_BLOCK_COUNT, fbpa_pkg::DATA_W'(POOL_DEPTH));
         else if (pick < 82)
            write_csr(fbpa_pkg::CSR_BLOCK_COUNT, $urandom_range(511, POOL_DEPTH + 1));
         else if (pick < 84)
            write_csr(fbpa_pkg::CSR_BLOCK_COUNT, 32'd0);
         else
            write_csr(fbpa_pkg::CSR_BLOCK_COUNT, $urandom_range(64, 13));

         calm = (phase == 3);
         queue_op(fbpa_pkg::OP_CREATE, $urandom);
         burst = $urandom_range(70, 30);
         for (int i = 0; i < burst; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               queue_op(fbpa_pkg::OP_ALLOC, $urandom);
            end else if (pick < 85) begin
               queue_op(fbpa_pkg::OP_RELEASE, pick_release_address());
            end else if (pick < 91) begin
               // A delete is always followed by a create, so that a pool
               // that was torn down early comes straight back.
               queue_op(fbpa_pkg::OP_DELETE, $urandom);
               queue_op(fbpa_pkg::OP_CREATE, $urandom);
            end else if (pick < 95) begin
               queue_op(fbpa_pkg::OP_CREATE, $urandom);
            end else begin
               queue_op(fbpa_pkg::OP_W'($urandom_range(3)), $urandom);
            end
         end

         // Once, the receiver goes quiet for a long while as this burst
         // streams in, so that the block backs up and stalls its input.
         if (phase == 1) begin
            @(posedge clock);
            hold_armed = 1'b1;
         end
         phase++;
      end

      while (request_backlog.size() != 0 || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_replies.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   // Watchdog.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench: FAIL");
      $finish;
   end

   // Request driver. A new item, or an idle cycle, is chosen only once the
   // previous item has been taken; an offered item is held unchanged.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         item_taken = 1'b0;
      end else if (!req_valid || item_taken) begin
         item_taken = 1'b0;
         if (request_backlog.size() != 0 &&
             (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
            req_valid <= 1'b1;
            req_op <= request_backlog[0].op;
            req_release_address <= request_backlog[0].address;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Every item the block accepts is applied to the pool copy right away;
   // the reply it should produce joins the back of the queue.
   always @(posedge clock) begin
      pool_reply_type predicted;
      if (!reset && req_valid && !req_stall) begin
         apply_pool_op(req_op, req_release_address, predicted);
         expected_replies.push_back(predicted);
         request_backlog.delete(0);
         item_taken = 1'b1;
      end
   end

   // Receiver stall: random idling, one long hold-off on request, and none
   // at all during the calm phase.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   task automatic check_field(input string label,
                              input logic [fbpa_pkg::ADDR_W-1:0] want,
                              input logic [fbpa_pkg::ADDR_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected 0x%h actual 0x%h", $time, label, want, got);
      end
   endtask

   // Reply monitor.
   always @(posedge clock) begin
      pool_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            mismatches++;
            $display("%0t: reply expected none actual status %0d address 0x%h free %0d",
                     $time, rsp_status, rsp_block_address, rsp_blocks_free);
         end else begin
            want = expected_replies.pop_front();
            check_field("status", fbpa_pkg::ADDR_W'(want.status),
                        fbpa_pkg::ADDR_W'(rsp_status));
            check_field("block_address", want.block_address, rsp_block_address);
            check_field("blocks_free", fbpa_pkg::ADDR_W'(want.blocks_free),
                        fbpa_pkg::ADDR_W'(rsp_blocks_free));
         end
      end
   end

endmodule
